FILE: rtl/vsa_pkg.sv
`timescale 1ns / 1ps

package vsa_pkg;

  localparam int SLOT_COUNT_DEF = 128;
  localparam int ID_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int POS_W   = 16;
  localparam int SLOT_W  = 7;
  localparam int LOUD_W  = 24;  // unsigned Q8.16 loudness
  localparam int D2_W    = 36;  // sum of three 17-bit squares
  localparam int ROOT_W  = 18;
  localparam int NUM_W   = 29;  // gain * 8192
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z = 2'd2;

  localparam logic [D2_W-1:0] NEAR_D2   = 36'd1024;  // 2 units squared
  localparam logic [9:0]      STEAL_NUM = 10'd922;   // 0.9 in 1/1024
  localparam int              STEAL_SH  = 10;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_REL  = 2'd1,
    KIND_MOVE = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_STOLEN   = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_MOVED    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_NEWL, S_SRD, S_SLD, S_SWAIT, S_IRD, S_ICHK, S_WRITE, S_RESULT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    LS_IDLE, LS_SQ, LS_SUM, LS_SQRT, LS_DIV, LS_DONE
  } loud_state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [GAIN_W-1:0] gain;
    logic              looping;
    logic              is3d;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
  } entry_t;

  typedef struct packed {
    logic    load_item;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    free_hit;
    logic    loud_new;
    logic    loud_slot;
    logic    best_init;
    logic    cmp_upd;
    logic    wr_new;
    logic    rel_hit;
    logic    mv_hit;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  busy_cur;
    logic  cnt_last;
    logic  loud_done;
    logic  match;
    logic  less;
    logic  found;
    logic  out_free;
  } sts_t;

endpackage

FILE: rtl/vsa_loud.sv
`timescale 1ns / 1ps

// Loudness unit: squares, bit-pair square root, restoring divide.
module vsa_loud import vsa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic                     is3d_i,
  input  logic signed [POS_W-1:0]  px_i,
  input  logic signed [POS_W-1:0]  py_i,
  input  logic signed [POS_W-1:0]  pz_i,
  input  logic signed [POS_W-1:0]  lx_i,
  input  logic signed [POS_W-1:0]  ly_i,
  input  logic signed [POS_W-1:0]  lz_i,
  output logic                     done_o,
  output logic [LOUD_W-1:0]        loud_o
);

  loud_state_e st_q, st_d;

  logic [GAIN_W-1:0]      gain_q;
  logic                   is3d_q;
  logic signed [POS_W:0]  dx_q, dy_q, dz_q;
  logic [2*POS_W+1:0]     sqx_q, sqy_q, sqz_q;
  logic [D2_W-1:0]        d2;
  logic [D2_W-1:0]        n_q, res_q, bit_q;
  logic [D2_W:0]          trial;
  logic [4:0]             it_q;
  logic [NUM_W-1:0]       num_q, q_q, q_next;
  logic [ROOT_W-1:0]      rem_q;
  logic [ROOT_W:0]        rem_sh;
  logic                   q_bit;
  logic                   near;
  logic [LOUD_W-1:0]      loud_q;

  assign d2     = D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
  assign near   = !is3d_q || (d2 <= NEAR_D2);
  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, res_q[ROOT_W-1:0]};
  assign q_next = {q_q[NUM_W-2:0], q_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      LS_IDLE: if (start_i) st_d = LS_SQ;
      LS_SQ:   st_d = LS_SUM;
      LS_SUM:  st_d = near ? LS_DONE : LS_SQRT;
      LS_SQRT: if (it_q == 5'd17) st_d = LS_DIV;
      LS_DIV:  if (it_q == 5'd28) st_d = LS_DONE;
      LS_DONE: st_d = LS_IDLE;
      default: st_d = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      LS_IDLE: begin
        gain_q <= gain_i;
        is3d_q <= is3d_i;
        dx_q   <= {px_i[POS_W-1], px_i} - {lx_i[POS_W-1], lx_i};
        dy_q   <= {py_i[POS_W-1], py_i} - {ly_i[POS_W-1], ly_i};
        dz_q   <= {pz_i[POS_W-1], pz_i} - {lz_i[POS_W-1], lz_i};
      end
      LS_SQ: begin
        // signed operands widen to the full square width
        sqx_q <= dx_q * dx_q;
        sqy_q <= dy_q * dy_q;
        sqz_q <= dz_q * dz_q;
      end
      LS_SUM: begin
        loud_q <= {gain_q, 8'd0};
        n_q    <= d2;
        res_q  <= '0;
        bit_q  <= D2_W'(1) << (D2_W - 2);
        it_q   <= '0;
      end
      LS_SQRT: begin
        if ({1'b0, n_q} >= trial) begin
          n_q   <= n_q - trial[D2_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        it_q  <= (it_q == 5'd17) ? 5'd0 : it_q + 5'd1;
        num_q <= {gain_q, 13'd0};
        q_q   <= '0;
        rem_q <= '0;
      end
      LS_DIV: begin
        rem_q <= q_bit ? ROOT_W'(rem_sh - {1'b0, res_q[ROOT_W-1:0]}) : rem_sh[ROOT_W-1:0];
        q_q   <= q_next;
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        it_q  <= it_q + 5'd1;
        if (it_q == 5'd28) loud_q <= q_next[LOUD_W-1:0];
      end
      default: ;
    endcase
  end

  assign done_o = (st_q == LS_DONE);
  assign loud_o = loud_q;

endmodule

FILE: rtl/vsa_datapath.sv
`timescale 1ns / 1ps

module vsa_datapath import vsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [POS_W-1:0]      cfg_data_i,
  input  logic [1:0]            kind_i,
  input  logic [ID_W-1:0]       sound_id_i,
  input  logic [GAIN_W-1:0]     gain_i,
  input  logic                  is_3d_i,
  input  logic                  looping_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [POS_W-1:0]      pos_z_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [2:0]            status_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [ID_W-1:0]       evicted_id_o,
  output logic                  evicted_requeue_o
);

  localparam int AW = $clog2(SLOT_COUNT);

  entry_t              mem [SLOT_COUNT];
  entry_t              rd_q, item_q, wdata;
  logic [AW-1:0]       waddr;
  logic                we;
  logic [SLOT_COUNT-1:0] busy_q;
  logic [AW-1:0]       cnt_q, pick_q;
  kind_e               kind_q;
  logic                found_q;
  logic [LOUD_W-1:0]   best_q;
  logic [ID_W-1:0]     ev_id_q;
  logic                ev_rq_q;
  logic [POS_W-1:0]    lx_q, ly_q, lz_q;
  logic                out_valid_q;
  status_e             out_st_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [ID_W-1:0]     out_ev_id_q;
  logic                out_ev_rq_q;
  logic                loud_done;
  logic [LOUD_W-1:0]   loud;
  logic [LOUD_W+9:0]   thr_full;
  entry_t              lsrc;
  logic                less;
  logic                out_free;

  // listener position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      lz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LISTENER_X: lx_q <= cfg_data_i;
        CFG_LISTENER_Y: ly_q <= cfg_data_i;
        CFG_LISTENER_Z: lz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot table
  assign we    = cmd_i.wr_new || cmd_i.mv_hit;
  assign waddr = cmd_i.wr_new ? pick_q : cnt_q;
  always_comb begin
    wdata = item_q;
    if (!cmd_i.wr_new) begin
      wdata    = rd_q;
      wdata.px = item_q.px;
      wdata.py = item_q.py;
      wdata.pz = item_q.pz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[cnt_q];
  end

  assign lsrc = cmd_i.loud_slot ? rd_q : item_q;

  vsa_loud u_loud (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.loud_new || cmd_i.loud_slot),
    .gain_i (lsrc.gain),
    .is3d_i (lsrc.is3d),
    .px_i   (lsrc.px),
    .py_i   (lsrc.py),
    .pz_i   (lsrc.pz),
    .lx_i   (lx_q),
    .ly_i   (ly_q),
    .lz_i   (lz_q),
    .done_o (loud_done),
    .loud_o (loud)
  );

  assign thr_full = loud * STEAL_NUM;
  assign less     = loud < best_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q         <= kind_e'(kind_i);
      item_q.id      <= sound_id_i;
      item_q.gain    <= gain_i;
      item_q.looping <= looping_i;
      item_q.is3d    <= is_3d_i;
      item_q.px      <= pos_x_i;
      item_q.py      <= pos_y_i;
      item_q.pz      <= pos_z_i;
    end
    if (cmd_i.best_init) best_q <= thr_full[LOUD_W+STEAL_SH-1:STEAL_SH];
    if (cmd_i.free_hit || cmd_i.rel_hit || (cmd_i.mv_hit && !found_q)) pick_q <= cnt_q;
    if (cmd_i.cmp_upd && less) begin
      best_q  <= loud;
      pick_q  <= cnt_q;
      ev_id_q <= rd_q.id;
      ev_rq_q <= rd_q.looping;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + AW'(1);
      if (cmd_i.load_item) found_q <= 1'b0;
      else if (cmd_i.free_hit || cmd_i.mv_hit || (cmd_i.cmp_upd && less)) found_q <= 1'b1;
      if (cmd_i.wr_new) busy_q[pick_q] <= 1'b1;
      if (cmd_i.rel_hit) busy_q[cnt_q] <= 1'b0;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_st_q    <= cmd_i.out_status;
      out_slot_q  <= (cmd_i.out_status == ST_REFUSED || cmd_i.out_status == ST_UNKNOWN)
                     ? '0 : SLOT_W'(pick_q);
      out_ev_id_q <= (cmd_i.out_status == ST_STOLEN) ? ev_id_q : '0;
      out_ev_rq_q <= (cmd_i.out_status == ST_STOLEN) ? ev_rq_q : 1'b0;
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.busy_cur  = busy_q[cnt_q];
  assign sts_o.cnt_last  = (cnt_q == AW'(SLOT_COUNT - 1));
  assign sts_o.loud_done = loud_done;
  assign sts_o.match     = busy_q[cnt_q] && (rd_q.id == item_q.id);
  assign sts_o.less      = less;
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign slot_o            = out_slot_q;
  assign evicted_id_o      = out_ev_id_q;
  assign evicted_requeue_o = out_ev_rq_q;

`ifndef NO_ASSERTIONS
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free) else $error("result loaded over a held result");
  a_steal_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.out_status == ST_STOLEN) |-> found_q)
    else $error("steal reported without a victim");
  a_write_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> found_q) else $error("slot write without a picked slot");
  a_steal_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp_upd |-> busy_q[cnt_q]) else $error("steal scan reached a free slot");
`endif

endmodule

FILE: rtl/vsa_ctrl.sv
`timescale 1ns / 1ps

module vsa_ctrl import vsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  ctrl_state_e st_q, st_d;
  status_e     res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      res_q <= ST_REFUSED;
    end else begin
      st_q  <= st_d;
      res_q <= res_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    res_d      = res_q;
    cmd_o      = '0;
    cmd_o.out_status = res_q;
    in_stall_o = (st_q != S_IDLE);
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          unique case (kind_e'(kind_i))
            KIND_REQ:  st_d = S_FREE;
            KIND_REL,
            KIND_MOVE: st_d = S_IRD;
            KIND_NONE: st_d = S_IDLE;
          endcase
        end
      end
      S_FREE: begin
        if (!sts_i.busy_cur) begin
          cmd_o.free_hit = 1'b1;
          res_d = ST_FREE;
          st_d  = S_WRITE;
        end else if (sts_i.cnt_last) begin
          cmd_o.loud_new = 1'b1;
          st_d = S_NEWL;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_NEWL: begin
        if (sts_i.loud_done) begin
          cmd_o.best_init = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          st_d = S_SRD;
        end
      end
      S_SRD: st_d = S_SLD;
      S_SLD: begin
        cmd_o.loud_slot = 1'b1;
        st_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts_i.loud_done) begin
          cmd_o.cmp_upd = 1'b1;
          if (sts_i.cnt_last) begin
            if (sts_i.found || sts_i.less) begin
              res_d = ST_STOLEN;
              st_d  = S_WRITE;
            end else begin
              res_d = ST_REFUSED;
              st_d  = S_RESULT;
            end
          end else begin
            cmd_o.cnt_inc = 1'b1;
            st_d = S_SRD;
          end
        end
      end
      S_IRD: st_d = S_ICHK;
      S_ICHK: begin
        if (sts_i.kind == KIND_REL) begin
          if (sts_i.match) begin
            cmd_o.rel_hit = 1'b1;
            res_d = ST_RELEASED;
            st_d  = S_RESULT;
          end else if (sts_i.cnt_last) begin
            res_d = ST_UNKNOWN;
            st_d  = S_RESULT;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            st_d = S_IRD;
          end
        end else begin
          cmd_o.mv_hit = sts_i.match;
          if (sts_i.cnt_last) begin
            res_d = (sts_i.found || sts_i.match) ? ST_MOVED : ST_UNKNOWN;
            st_d  = S_RESULT;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            st_d = S_IRD;
          end
        end
      end
      S_WRITE: begin
        cmd_o.wr_new = 1'b1;
        st_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_loud_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.loud_done |-> (st_q == S_NEWL || st_q == S_SWAIT))
    else $error("loudness result outside a wait state");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> st_q == S_IDLE) else $error("result without return to idle");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> st_q == S_IDLE) else $error("request taken while busy");
`endif

endmodule

FILE: rtl/voice_slot_allocator.sv
`timescale 1ns / 1ps
// Requests take the first free slot; release and move read each slot, then check it.
// Stealing: a free search over all slots, then the new loudness, then per slot
// a read, the squares and, if distant 3D, an 18-step root and a 29-step divide.
// Throughput: one request at a time; the next is taken once the previous result is queued.
// Reset: asynchronous active low; all slots free, listener at origin, output empty.
module voice_slot_allocator import vsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [ID_W-1:0]      sound_id_i,
  input  logic [GAIN_W-1:0]    gain_i,
  input  logic                 is_3d_i,
  input  logic                 looping_i,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [POS_W-1:0]     pos_z_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [ID_W-1:0]      evicted_id_o,
  output logic                 evicted_requeue_o,
  // listener position writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: slot scans and loudness handshakes
  vsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .kind_i    (kind_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // slot table, busy bits, loudness unit and result register
  vsa_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (kind_i),
    .sound_id_i       (sound_id_i),
    .gain_i           (gain_i),
    .is_3d_i          (is_3d_i),
    .looping_i        (looping_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .evicted_id_o     (evicted_id_o),
    .evicted_requeue_o(evicted_requeue_o)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

// Voice slot allocator bench.
// A request is taken at a rising edge with in_valid_i high and in_stall_o low.
// A result is taken at a rising edge with out_valid_o high and out_stall_i low.
// Every accepted request goes through a behavioral copy of the slot table.
// That copy predicts the result, which waits in a queue until the block answers.

import vsa_pkg::*;

class slot_scoreboard;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   evicted_id;
    logic              requeue;
  } outcome_t;

  // listener position, signed Q12.4
  logic signed [15:0] lis_x, lis_y, lis_z;
  bit                 busy [128];
  logic [15:0]        ids [128];
  logic [15:0]        gains [128];
  bit                 is3d [128];
  bit                 loops [128];
  logic signed [15:0] px [128], py [128], pz [128];
  outcome_t           pending [$];
  int                 errors;
  int                 steals;
  int                 refusals;

  function new();
    lis_x = 0;
    lis_y = 0;
    lis_z = 0;
    errors = 0;
    steals = 0;
    refusals = 0;
    foreach (busy[i]) busy[i] = 0;
  endfunction

  function void set_listener(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_LISTENER_X: lis_x = val;
      CFG_LISTENER_Y: lis_y = val;
      CFG_LISTENER_Z: lis_z = val;
      default: ;
    endcase
  endfunction

  // Integer square root of a value that is never wider than 36 bits.
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Loudness in unsigned Q8.16.
  // Close or flat sounds keep their full gain; distant 3D sounds fall off with distance.
  function automatic longint unsigned loud(logic [15:0] g, bit d3,
      logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    longint signed dx, dy, dz;
    longint unsigned d2;
    if (!d3) return longint'(g) << 8;
    dx = longint'(x) - longint'(lis_x);
    dy = longint'(y) - longint'(lis_y);
    dz = longint'(z) - longint'(lis_z);
    d2 = dx * dx + dy * dy + dz * dz;
    if (d2 <= 1024) return longint'(g) << 8;
    return (longint'(g) * 8192) / int_root(d2);
  endfunction

  function void note_request(kind_e k, logic [15:0] id, logic [15:0] g, bit d3, bit lp,
      logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    outcome_t o;
    int pick;
    longint unsigned best, l;
    o = '{ST_REFUSED, '0, '0, 1'b0};
    pick = -1;
    if (k == KIND_NONE) return;
    if (k == KIND_REQ) begin
      foreach (busy[i]) if (!busy[i]) begin
        pick = i;
        break;
      end
      if (pick >= 0) begin
        o.status = ST_FREE;
      end else begin
        // Table is full: look for a quieter victim below 922/1024 of the new loudness.
        best = (loud(g, d3, x, y, z) * 922) >> 10;
        foreach (busy[i]) begin
          l = loud(gains[i], is3d[i], px[i], py[i], pz[i]);
          if (l < best) begin
            best = l;
            pick = i;
          end
        end
        if (pick >= 0) begin
          o.status = ST_STOLEN;
          o.evicted_id = ids[pick];
          o.requeue = loops[pick];
          steals++;
        end else begin
          refusals++;
        end
      end
      if (pick >= 0) begin
        o.slot = SLOT_W'(pick);
        busy[pick] = 1;
        ids[pick] = id;
        gains[pick] = g;
        is3d[pick] = d3;
        loops[pick] = lp;
        px[pick] = x;
        py[pick] = y;
        pz[pick] = z;
      end
    end else if (k == KIND_REL) begin
      o.status = ST_UNKNOWN;
      foreach (busy[i]) if (busy[i] && ids[i] == id) begin
        busy[i] = 0;
        o.status = ST_RELEASED;
        o.slot = SLOT_W'(i);
        break;
      end
    end else begin
      // Every slot holding this id moves; the first one found is the one reported.
      o.status = ST_UNKNOWN;
      foreach (busy[i]) if (busy[i] && ids[i] == id) begin
        px[i] = x;
        py[i] = y;
        pz[i] = z;
        if (o.status != ST_MOVED) begin
          o.status = ST_MOVED;
          o.slot = SLOT_W'(i);
        end
      end
    end
    pending.push_back(o);
  endfunction

  function void check_result(logic [2:0] st, logic [SLOT_W-1:0] sl, logic [15:0] ev,
      logic rq);
    outcome_t o;
    if (pending.size() == 0) begin
      $error("result with no request waiting: status %0d slot %0d", st, sl);
      errors++;
      return;
    end
    o = pending.pop_front();
    if (st !== o.status) begin
      $error("status: expected %0d, got %0d", o.status, st);
      errors++;
    end
    if (sl !== o.slot) begin
      $error("slot: expected %0d, got %0d", o.slot, sl);
      errors++;
    end
    if (ev !== o.evicted_id) begin
      $error("evicted_id: expected %0h, got %0h", o.evicted_id, ev);
      errors++;
    end
    if (rq !== o.requeue) begin
      $error("evicted_requeue: expected %0d, got %0d", o.requeue, rq);
      errors++;
    end
  endfunction
endclass

module tb;
  import vsa_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [15:0] sound_id = '0, gain = '0;
  logic        is_3d = 0, looping = 0;
  logic [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [SLOT_W-1:0] slot;
  logic [15:0] evicted_id;
  logic        evicted_requeue;
  logic        cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  slot_scoreboard sb = new();
  int  hold_cycles = 0;     // long receiver hold-off, counted in the stall process
  bit  quiet_out = 0;       // receiver stall pattern off for stretches
  int  requests_sent = 0;
  int  moves_and_releases = 0;

  always #2 clk = ~clk;

  voice_slot_allocator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .sound_id_i(sound_id), .gain_i(gain),
    .is_3d_i(is_3d), .looping_i(looping),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .slot_o(slot), .evicted_id_o(evicted_id),
    .evicted_requeue_o(evicted_requeue),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Results are checked on the edge at which they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(status, slot, evicted_id, evicted_requeue);
  end

  // Receiver stall pattern. A hold-off request pins stall high for a counted stretch.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send(kind_e k, logic [15:0] id, logic [15:0] g, bit d3, bit lp,
      logic [15:0] x, logic [15:0] y, logic [15:0] z);
    kind <= k;
    sound_id <= id;
    gain <= g;
    is_3d <= d3;
    looping <= lp;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, id, g, d3, lp, x, y, z);
    if (k == KIND_REQ) requests_sent++;
    else if (k != KIND_NONE) moves_and_releases++;
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Let every expected result come back, then some slack for ignored items.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8000) @(posedge clk);
  endtask

  task automatic write_listener(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_listener(idx, val);
  endtask

  // Random request biased toward a small id pool so releases and moves hit.
  task automatic random_item();
    kind_e k;
    logic [15:0] id;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) k = KIND_REQ;
    else if (r < 75) k = KIND_REL;
    else if (r < 96) k = KIND_MOVE;
    else k = KIND_NONE;
    id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    send(k, id, 16'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
         ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 127) - 64)),
         ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 127) - 64)),
         ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 127) - 64)));
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        random_item();
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
    end
  endtask

  initial begin
    #2000000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: listener at the origin, table fills up, then steals and refusals.
    send(KIND_REL, 16'h0001, 0, 0, 0, 0, 0, 0);            // unknown id on empty table
    send(KIND_MOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0);           // unknown id on empty table
    send(KIND_NONE, 16'h1234, 16'hFFFF, 1, 1, 0, 0, 0);    // ignored kind
    send(KIND_REQ, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
    send(KIND_REQ, 16'hFFFF, 16'hFFFF, 1, 1, 16'h7FFF, 16'h8000, 16'h7FFF);
    send(KIND_REQ, 16'h0005, 16'h0100, 1, 0, 16'h0020, 16'h0000, 16'h0000); // exactly 2 units
    send(KIND_REQ, 16'h0005, 16'h0100, 1, 1, 16'h0021, 16'h0000, 16'h0000); // dup id, farther
    send(KIND_MOVE, 16'h0005, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000);       // moves both
    send(KIND_REL, 16'h0005, 0, 0, 0, 0, 0, 0);                            // lowest only
    send(KIND_REL, 16'h0005, 0, 0, 0, 0, 0, 0);
    // Fill the rest with quiet 3D sounds far away, every other one looping.
    for (int i = 0; i < 130; i++)
      send(KIND_REQ, 16'(16'h0100 + i), 16'($urandom_range(1, 64)), 1, i[0],
           16'h4000, 16'h4000, 16'($urandom));
    send(KIND_REQ, 16'hAAAA, 16'hFFFF, 0, 1, 0, 0, 0);     // loud: steals
    send(KIND_REQ, 16'hBBBB, 16'h0000, 0, 0, 0, 0, 0);     // silent: refused
    send(KIND_REQ, 16'hCCCC, 16'h0001, 1, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    drain();

    // Listener extremes, each register written, with random traffic between.
    write_listener(CFG_LISTENER_X, 16'h7FFF);
    write_listener(CFG_LISTENER_Y, 16'h8000);
    write_listener(CFG_LISTENER_Z, 16'h7FFF);
    random_phase(250);
    drain();
    write_listener(CFG_LISTENER_X, 16'h8000);
    write_listener(CFG_LISTENER_Y, 16'h7FFF);
    write_listener(CFG_LISTENER_Z, 16'h8000);
    // Long receiver hold-off while the sender keeps pushing.
    hold_cycles = 3000;
    random_phase(250);
    drain();
    write_listener(CFG_LISTENER_X, 16'h0000);
    write_listener(CFG_LISTENER_Y, 16'h0000);
    write_listener(CFG_LISTENER_Z, 16'h0000);
    quiet_out = 1;
    random_phase(150);
    quiet_out = 0;
    random_phase(150);
    drain();
    write_listener(CFG_LISTENER_X, 16'($urandom));
    write_listener(CFG_LISTENER_Y, 16'($urandom));
    write_listener(CFG_LISTENER_Z, 16'($urandom));
    random_phase(220);
    drain();

    $display("covered %0d slot requests and %0d releases/moves; %0d steals, %0d refusals",
             requests_sent, moves_and_releases, sb.steals, sb.refusals);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
